/* hdl/gelu_pkg.sv */
// Shared types, constants and the power-of-two table for the GELU pipeline.
package gelu_pkg;

    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 12;
    localparam int A_W        = 19;
    localparam int T_W        = 22;
    localparam int DIV_STAGES = 17;

    localparam logic [11:0] K_CUBIC = 12'd2930;
    localparam logic [15:0] K_SCALE = 16'd52290;
    localparam logic [16:0] K_LOG2E = 17'd94548;
    localparam logic [15:0] K_LN2   = 16'd45426;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    typedef struct packed {
        logic [A_W-1:0] a;
        logic           neg;
        logic           big;
        logic           last;
    } side_t;

    function automatic logic [16:0] pow2_neg(input logic [3:0] k);
        logic [16:0] r;
        begin
            case (k)
                4'd0:    r = 17'd65536;
                4'd1:    r = 17'd62757;
                4'd2:    r = 17'd60097;
                4'd3:    r = 17'd57549;
                4'd4:    r = 17'd55109;
                4'd5:    r = 17'd52773;
                4'd6:    r = 17'd50535;
                4'd7:    r = 17'd48393;
                4'd8:    r = 17'd46341;
                4'd9:    r = 17'd44376;
                4'd10:   r = 17'd42495;
                4'd11:   r = 17'd40693;
                4'd12:   r = 17'd38968;
                4'd13:   r = 17'd37316;
                4'd14:   r = 17'd35734;
                default: r = 17'd34219;
            endcase
            return r;
        end
    endfunction

endpackage

/* hdl/gelu_front.sv */
// Front pipeline: magnitude, cubic term and the scaled tanh argument.
module gelu_front
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [15:0]              sample,
    input  logic                     last,
    output logic                     out_valid,
    output gelu_pkg::side_t          out_side,
    output logic [gelu_pkg::T_W-1:0] t
);

    logic            neg;
    logic [16:0]     mag;
    gelu_pkg::side_t side0;
    logic [37:0]     sq;
    logic [40:0]     cube;
    logic [36:0]     cub_k;
    logic [37:0]     sc;

    logic            v1_reg, v2_reg, v3_reg, v4_reg;
    gelu_pkg::side_t s1_reg, s2_reg, s3_reg, s4_reg;
    logic [21:0]     a2_reg;
    logic [24:0]     a3_reg;
    logic [21:0]     s_reg;
    logic [21:0]     t_reg;

    always_comb
    begin
        neg        = sample[15];
        mag        = neg ? ({1'b0, ~sample} + 17'd1) : {1'b0, sample};
        side0.neg  = neg;
        side0.big  = mag[16] | mag[15];
        side0.a    = {mag[14:0], 4'd0};
        side0.last = last;
        sq         = 38'(side0.a) * 38'(side0.a);
        cube       = 41'(a2_reg) * 41'(s1_reg.a);
        cub_k      = 37'(a3_reg) * 37'(gelu_pkg::K_CUBIC);
        sc         = 38'(s_reg) * 38'(gelu_pkg::K_SCALE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= side0;
            a2_reg <= sq[37:16];
            s2_reg <= s1_reg;
            a3_reg <= cube[40:16];
            s3_reg <= s2_reg;
            s_reg  <= 22'(s2_reg.a) + 22'(cub_k[36:16]);
            s4_reg <= s3_reg;
            t_reg  <= sc[37:16];
        end
    end

    assign out_valid = v4_reg;
    assign out_side  = s4_reg;
    assign t         = t_reg;

endmodule

/* hdl/gelu_exp.sv */
// Exponential pipeline: e^(-2t) from a table and a short series, set up for the divide.
module gelu_exp
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  gelu_pkg::side_t          in_side,
    input  logic [gelu_pkg::T_W-1:0] t,
    output logic                     out_valid,
    output gelu_pkg::side_t          out_side,
    output logic [32:0]              num,
    output logic [17:0]              den
);

    logic            sat;
    logic [36:0]     vp;
    logic [27:0]     yp;
    logic [23:0]     y2p;
    logic [19:0]     y3p;
    logic [3:0]      y3;
    logic [1:0]      d6;
    logic [32:0]     ep;
    logic [16:0]     e;

    logic            v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    gelu_pkg::side_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg;
    logic            sat1_reg, sat2_reg, sat3_reg, sat4_reg, sat5_reg;
    logic [20:0]     v_reg;
    logic [11:0]     y2_y_reg, y3_y_reg;
    logic [7:0]      y2_reg;
    logic [3:0]      hi2_reg, hi3_reg, hi4_reg;
    logic [4:0]      n2_reg, n3_reg, n4_reg, n5_reg;
    logic [16:0]     p_reg;
    logic [16:0]     e0_reg;
    logic [32:0]     num_reg;
    logic [17:0]     den_reg;

    always_comb
    begin
        sat = |t[21:19];
        vp  = 37'({t[18:0], 1'b0}) * 37'(gelu_pkg::K_LOG2E);
        yp  = 28'(v_reg[11:0]) * 28'(gelu_pkg::K_LN2);
        y2p = 24'(y2_y_reg) * 24'(y2_y_reg);
        y3p = 20'(y2_reg) * 20'(y3_y_reg);
        y3  = y3p[19:16];
        d6  = (y3 >= 4'd12) ? 2'd2 : ((y3 >= 4'd6) ? 2'd1 : 2'd0);
        ep  = 33'(gelu_pkg::pow2_neg(hi4_reg)) * 33'(p_reg);
        e   = sat5_reg ? 17'd0 : (e0_reg >> n5_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg   <= in_side;
            sat1_reg <= sat;
            v_reg    <= vp[36:16];

            s2_reg   <= s1_reg;
            sat2_reg <= sat1_reg;
            y2_y_reg <= yp[27:16];
            hi2_reg  <= v_reg[15:12];
            n2_reg   <= v_reg[20:16];

            s3_reg   <= s2_reg;
            sat3_reg <= sat2_reg;
            y2_reg   <= y2p[23:16];
            y3_y_reg <= y2_y_reg;
            hi3_reg  <= hi2_reg;
            n3_reg   <= n2_reg;

            s4_reg   <= s3_reg;
            sat4_reg <= sat3_reg;
            p_reg    <= gelu_pkg::ONE_Q16 - 17'(y3_y_reg) + 17'(y2_reg[7:1]) - 17'(d6);
            hi4_reg  <= hi3_reg;
            n4_reg   <= n3_reg;

            s5_reg   <= s4_reg;
            sat5_reg <= sat4_reg;
            e0_reg   <= ep[32:16];
            n5_reg   <= n4_reg;

            s6_reg   <= s5_reg;
            num_reg  <= {gelu_pkg::ONE_Q16 - e, 16'd0};
            den_reg  <= 18'(gelu_pkg::ONE_Q16) + 18'(e);
        end
    end

    assign out_valid = v6_reg;
    assign out_side  = s6_reg;
    assign num       = num_reg;
    assign den       = den_reg;

endmodule

/* hdl/gelu_div.sv */
// Pipelined restoring divider, one quotient bit per stage, giving tanh in Q16.
module gelu_div
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  gelu_pkg::side_t in_side,
    input  logic [32:0]     num,
    input  logic [17:0]     den,
    output logic            out_valid,
    output gelu_pkg::side_t out_side,
    output logic [16:0]     quot
);

    localparam int N = gelu_pkg::DIV_STAGES;

    logic            v_reg    [N];
    gelu_pkg::side_t side_reg [N];
    logic [32:0]     rem_reg  [N];
    logic [17:0]     den_reg  [N];
    logic [16:0]     q_reg    [N];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_stage
            localparam int B = N - 1 - k;
            logic            v_in;
            gelu_pkg::side_t side_in;
            logic [32:0]     rem_in;
            logic [17:0]     den_in;
            logic [16:0]     q_in;
            logic [34:0]     dd;
            logic            ge;
            logic [32:0]     rem_next;
            logic [16:0]     q_next;

            if (k == 0)
            begin : g_first
                assign v_in    = in_valid;
                assign side_in = in_side;
                assign rem_in  = num;
                assign den_in  = den;
                assign q_in    = 17'd0;
            end
            else
            begin : g_rest
                assign v_in    = v_reg[k-1];
                assign side_in = side_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign den_in  = den_reg[k-1];
                assign q_in    = q_reg[k-1];
            end

            always_comb
            begin
                dd       = 35'(den_in) << B;
                ge       = {2'b00, rem_in} >= dd;
                rem_next = ge ? (rem_in - dd[32:0]) : rem_in;
                q_next   = q_in;
                q_next[B] = ge;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[k] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    side_reg[k] <= side_in;
                    rem_reg[k]  <= rem_next;
                    den_reg[k]  <= den_in;
                    q_reg[k]    <= q_next;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[N-1];
    assign out_side  = side_reg[N-1];
    assign quot      = q_reg[N-1];

endmodule

/* hdl/gelu_activation.sv */
// GELU activation, tanh form, fully pipelined: top level with final scaling and output register.
// Throughput is one request per cycle while the output is not stalled; the 17-stage divider sets most of the depth.
// A stall on the output freezes the whole pipeline, so no request is lost or repeated.
// Reset clears every valid bit at once; no clearing pass is needed.
module gelu_activation
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] sample_in,
    input  logic        last_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] gelu_out,
    output logic        last_out
);

    logic                     en;
    logic                     f_valid, x_valid, d_valid;
    gelu_pkg::side_t          f_side, x_side, d_side;
    logic [gelu_pkg::T_W-1:0] t;
    logic [32:0]              num;
    logic [17:0]              den;
    logic [16:0]              th;

    logic [17:0]              factor;
    logic [36:0]              prod;
    logic [20:0]              rnd;
    logic [16:0]              m;
    logic [15:0]              res;

    logic                     g_valid_reg;
    gelu_pkg::side_t          g_side_reg;
    logic [19:0]              g_reg;
    logic                     out_valid_reg;
    logic [15:0]              gelu_reg;
    logic                     last_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    gelu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .sample    (sample_in),
        .last      (last_in),
        .out_valid (f_valid),
        .out_side  (f_side),
        .t         (t)
    );

    gelu_exp u_exp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_side   (f_side),
        .t         (t),
        .out_valid (x_valid),
        .out_side  (x_side),
        .num       (num),
        .den       (den)
    );

    gelu_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (x_valid),
        .in_side   (x_side),
        .num       (num),
        .den       (den),
        .out_valid (d_valid),
        .out_side  (d_side),
        .quot      (th)
    );

    always_comb
    begin
        factor = d_side.neg ? (18'(gelu_pkg::ONE_Q16) - 18'(th))
                            : (18'(gelu_pkg::ONE_Q16) + 18'(th));
        prod   = 37'(d_side.a) * 37'(factor);
        rnd    = 21'(g_reg) + 21'd8;
        m      = rnd[20:4];
        if (g_side_reg.big)
        begin
            res = 16'd0;
        end
        else if (g_side_reg.neg)
        begin
            res = 16'd0 - m[15:0];
        end
        else if (m > 17'd32767)
        begin
            res = 16'h7FFF;
        end
        else
        begin
            res = m[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            g_valid_reg   <= d_valid;
            out_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_side_reg <= d_side;
            g_reg      <= prod[36:17];
            gelu_reg   <= res;
            last_reg   <= g_side_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign gelu_out  = gelu_reg;
    assign last_out  = last_reg;

    a_tanh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        d_valid |-> th <= 17'd65536)
        else $error("tanh magnitude above one");

    a_neg_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && gelu_out[15] |-> $signed(gelu_out) > -16'sd1024)
        else $error("negative GELU result below its floor");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(gelu_out) && $stable(last_out))
        else $error("stalled result changed");

endmodule
